### design/hkv_pkg.sv
// ----------------------------------------------------------------------------
// hkv_pkg: shared types and constants of the key-value hash table
// Defines the request codes, the result status codes, the sequencer states
// and the default sizes of the table.
// ----------------------------------------------------------------------------
package hkv_pkg;

  // Default table geometry and field widths.
  localparam int MaxBucketsLog2Def = 6;
  localparam int SlotsPerBucketDef = 4;
  localparam int KeyBitsDef        = 32;
  localparam int ValueBitsDef      = 32;

  // Configuration register.
  localparam int       CfgLog2W       = 3;
  localparam int       CfgDataW       = 32;
  localparam int       CfgAddrW       = 3;
  localparam logic [CfgLog2W-1:0] BucketLog2Reset = 3'd4;

  // Field widths fixed by the request and result formats.
  localparam int ReqW    = 2;
  localparam int StatusW = 3;

  // Request codes.
  typedef enum logic [ReqW-1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_REMOVE = 2'd2
  } req_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    STAT_INSERTED = 3'd0,
    STAT_UPDATED  = 3'd1,
    STAT_FOUND    = 3'd2,
    STAT_MISSING  = 3'd3,
    STAT_FULL     = 3'd4
  } status_e;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

endpackage

### design/hash_key_value_table.sv
// ----------------------------------------------------------------------------
// hash_key_value_table: key-value hash table with bounded buckets
// Insert, lookup and remove requests on a table of fixed-size buckets. The
// bucket is the key's low bits; one shared compare unit walks the slots of
// the bucket through a slot memory with one read port and one write port.
//
// The slots of the bucket are read one per cycle and compared in turn; the
// table update is then committed. The input is not ready while a request
// walks its bucket. A pending result does not block the next input
// transfer.
// Reset: table empty, entry count zero, bucket register 4. A write to the
// bucket register empties the table at once; the slot memory is not cleared.
// ----------------------------------------------------------------------------
module hash_key_value_table #(
  parameter int MAX_BUCKETS_LOG2 = hkv_pkg::MaxBucketsLog2Def,
  parameter int SLOTS_PER_BUCKET = hkv_pkg::SlotsPerBucketDef,
  parameter int KEY_BITS         = hkv_pkg::KeyBitsDef,
  parameter int VALUE_BITS       = hkv_pkg::ValueBitsDef,
  // Derived sizes, not meant to be overridden.
  parameter int TABLE_SLOTS = (2 ** MAX_BUCKETS_LOG2) * SLOTS_PER_BUCKET,
  parameter int CNT_W       = $clog2(TABLE_SLOTS + 1),
  parameter int IN_W        = ((hkv_pkg::ReqW + KEY_BITS + VALUE_BITS + 7) / 8) * 8,
  parameter int OUT_W       = ((hkv_pkg::StatusW + VALUE_BITS + CNT_W + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // Fields from bit 0: req_type, key, new_value, zero fill.
  input  logic [IN_W-1:0]               s_axis_tdata,
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // Fields from bit 0: status, found_value, entry_count, zero fill.
  output logic [OUT_W-1:0]              m_axis_tdata,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hkv_pkg::CfgAddrW-1:0]  paddr,
  input  logic [hkv_pkg::CfgDataW-1:0]  pwdata,
  output logic [hkv_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);
  import hkv_pkg::*;

  localparam int AddrW    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int SlotCntW = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int EntryW   = KEY_BITS + VALUE_BITS;
  localparam int KeyExtW  = (KEY_BITS > MAX_BUCKETS_LOG2) ? KEY_BITS : MAX_BUCKETS_LOG2;
  localparam int OutUsedW = StatusW + VALUE_BITS + CNT_W;

  // Sequencer and request registers.
  state_e                   state_q, state_d;
  req_e                     req_q, req_d;
  logic [KEY_BITS-1:0]      key_q, key_d;
  logic [VALUE_BITS-1:0]    val_q, val_d;
  logic [AddrW-1:0]         base_q, base_d;
  logic [SlotCntW-1:0]      rd_cnt_q, rd_cnt_d;
  logic                     cmp_vld_q, cmp_vld_d;
  logic [AddrW-1:0]         cmp_idx_q, cmp_idx_d;
  logic                     vld_rd_q;
  logic [EntryW-1:0]        rd_data_q;
  logic                     hit_q, hit_d;
  logic [AddrW-1:0]         hit_idx_q, hit_idx_d;
  logic [VALUE_BITS-1:0]    hit_val_q, hit_val_d;
  logic                     free_q, free_d;
  logic [AddrW-1:0]         free_idx_q, free_idx_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [CfgLog2W-1:0]      cfg_log2_q;
  logic [TABLE_SLOTS-1:0]   slot_valid_q;
  logic                     m_tvalid_q, m_tvalid_d;
  logic [OutUsedW-1:0]      out_data_q, out_data_d;

  // Slot memory: key in the upper part, value in the lower part.
  logic [EntryW-1:0]        mem_q [TABLE_SLOTS];

  logic                     s_fire, cfg_wr, done_fire;
  logic                     rd_en, wr_en, set_vld, clr_vld;
  logic [AddrW-1:0]         rd_addr, wr_addr;
  logic [CfgLog2W:0]        lg_eff;
  logic [MAX_BUCKETS_LOG2-1:0] bucket_mask;
  logic [KeyExtW-1:0]       key_ext;
  logic [MAX_BUCKETS_LOG2-1:0] bucket;
  status_e                  status_d;
  logic [VALUE_BITS-1:0]    found_d;
  logic [KEY_BITS-1:0]      rd_key;

  assign s_fire    = s_axis_tvalid && s_axis_tready;
  assign cfg_wr    = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign done_fire = (state_q == S_DONE) && (!m_tvalid_q || m_axis_tready);
  assign rd_key    = rd_data_q[EntryW-1 -: KEY_BITS];

  // Configuration port: always ready, one register at word zero.
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == 1'b0) begin
      prdata[CfgLog2W-1:0] = cfg_log2_q;
    end
  end

  // Bucket select: key low bits under a mask of the clamped bucket log2.
  always_comb begin
    if (int'(cfg_log2_q) > MAX_BUCKETS_LOG2) begin
      lg_eff = (CfgLog2W + 1)'(MAX_BUCKETS_LOG2);
    end else begin
      lg_eff = {1'b0, cfg_log2_q};
    end
    for (int i = 0; i < MAX_BUCKETS_LOG2; i++) begin
      bucket_mask[i] = (i < int'(lg_eff));
    end
    key_ext = KeyExtW'(s_axis_tdata[ReqW +: KEY_BITS]);
    bucket  = key_ext[MAX_BUCKETS_LOG2-1:0] & bucket_mask;
  end

  // Sequencer: issue one slot read per cycle, compare one slot per cycle,
  // then, once the result register is free, commit the table update and load the result register.
  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    key_d      = key_q;
    val_d      = val_q;
    base_d     = base_q;
    rd_cnt_d   = rd_cnt_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_val_d  = hit_val_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    cnt_d      = cnt_q;
    m_tvalid_d = m_tvalid_q;
    out_data_d = out_data_q;
    rd_en      = 1'b0;
    rd_addr    = base_q + AddrW'(rd_cnt_q);
    wr_en      = 1'b0;
    wr_addr    = hit_idx_q;
    set_vld    = 1'b0;
    clr_vld    = 1'b0;
    status_d   = STAT_MISSING;
    found_d    = '0;

    if (m_tvalid_q && m_axis_tready) begin
      m_tvalid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          req_d    = req_e'(s_axis_tdata[ReqW-1:0]);
          key_d    = s_axis_tdata[ReqW +: KEY_BITS];
          val_d    = s_axis_tdata[ReqW + KEY_BITS +: VALUE_BITS];
          base_d   = AddrW'(int'(bucket) * SLOTS_PER_BUCKET);
          rd_cnt_d = '0;
          hit_d    = 1'b0;
          free_d   = 1'b0;
          state_d  = S_SCAN;
        end
      end
      S_SCAN: begin
        // Read side.
        if (int'(rd_cnt_q) < SLOTS_PER_BUCKET) begin
          rd_en     = 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_addr;
          rd_cnt_d  = rd_cnt_q + SlotCntW'(1);
        end
        // Compare side: first matching valid slot, first empty slot.
        if (cmp_vld_q) begin
          if (vld_rd_q) begin
            if (!hit_q && (rd_key == key_q)) begin
              hit_d     = 1'b1;
              hit_idx_d = cmp_idx_q;
              hit_val_d = rd_data_q[VALUE_BITS-1:0];
            end
          end else if (!free_q) begin
            free_d     = 1'b1;
            free_idx_d = cmp_idx_q;
          end
        end
        if ((int'(rd_cnt_q) == SLOTS_PER_BUCKET) && cmp_vld_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        case (req_q)
          REQ_INSERT: begin
            if (hit_q) begin
              wr_en    = 1'b1;
              wr_addr  = hit_idx_q;
              status_d = STAT_UPDATED;
            end else if (free_q) begin
              wr_en    = 1'b1;
              wr_addr  = free_idx_q;
              set_vld  = 1'b1;
              cnt_d    = cnt_q + CNT_W'(1);
              status_d = STAT_INSERTED;
            end else begin
              status_d = STAT_FULL;
            end
          end
          REQ_LOOKUP: begin
            if (hit_q) begin
              status_d = STAT_FOUND;
              found_d  = hit_val_q;
            end
          end
          REQ_REMOVE: begin
            if (hit_q) begin
              clr_vld  = 1'b1;
              wr_addr  = hit_idx_q;
              cnt_d    = cnt_q - CNT_W'(1);
              status_d = STAT_FOUND;
            end
          end
          default: begin
            status_d = STAT_MISSING;
          end
        endcase
        if (done_fire) begin
          m_tvalid_d = 1'b1;
          out_data_d = {cnt_d, found_d, status_d};
          state_d    = S_IDLE;
        end else begin
          // Hold the table until the result register is free.
          wr_en   = 1'b0;
          set_vld = 1'b0;
          clr_vld = 1'b0;
          cnt_d   = cnt_q;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      rd_cnt_q   <= '0;
      cmp_vld_q  <= 1'b0;
      vld_rd_q   <= 1'b0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      m_tvalid_q <= 1'b0;
      cnt_q      <= '0;
      cfg_log2_q <= BucketLog2Reset;
    end else begin
      state_q    <= state_d;
      rd_cnt_q   <= rd_cnt_d;
      cmp_vld_q  <= cmp_vld_d;
      hit_q      <= hit_d;
      free_q     <= free_d;
      m_tvalid_q <= m_tvalid_d;
      if (rd_en) begin
        vld_rd_q <= slot_valid_q[rd_addr];
      end
      if (cfg_wr) begin
        cfg_log2_q <= pwdata[CfgLog2W-1:0];
        cnt_q      <= '0;
      end else begin
        cnt_q <= cnt_d;
      end
    end
  end

  // Slot valid bits: a register write empties the whole table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
    end else if (cfg_wr) begin
      slot_valid_q <= '0;
    end else if (set_vld) begin
      slot_valid_q[wr_addr] <= 1'b1;
    end else if (clr_vld) begin
      slot_valid_q[wr_addr] <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    key_q      <= key_d;
    val_q      <= val_d;
    base_q     <= base_d;
    cmp_idx_q  <= cmp_idx_d;
    hit_idx_q  <= hit_idx_d;
    hit_val_q  <= hit_val_d;
    free_idx_q <= free_idx_d;
    out_data_q <= out_data_d;
  end

  // Slot memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= {key_q, val_q};
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Stream outputs.
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = OUT_W'(out_data_q);

  // The entry count never exceeds the table size.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= TABLE_SLOTS)
    else $error("entry count above table size");

  // An accepted request starts a bucket walk in the next cycle.
  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> (state_q == S_SCAN) && (rd_cnt_q == '0))
    else $error("bucket walk did not start");

  // A new entry raises the count by one.
  a_insert_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_fire && set_vld && !cfg_wr) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("insert did not raise the entry count");

  // The slot read counter stays within one bucket.
  a_rd_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(rd_cnt_q) <= SLOTS_PER_BUCKET)
    else $error("slot read counter overran the bucket");

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for hash_key_value_table
// Drives insert, lookup and remove requests into the request stream and
// predicts each result with a behavioral copy of the bounded-bucket table.
// Results are matched in order, field by field. The bucket register is swept
// over its whole range through the configuration port. Both streams idle at
// random, and the result side holds off for a long stretch once.
// ----------------------------------------------------------------------------
module tb;
  import hkv_pkg::*;

  localparam int SLOTS       = SlotsPerBucketDef;
  localparam int LOG2_CAP    = MaxBucketsLog2Def;
  localparam int TABLE_SLOTS = (2 ** LOG2_CAP) * SLOTS;
  localparam int IN_W        = 72;
  localparam int OUT_W       = 48;
  localparam int LATENCY     = SLOTS + 2;
  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_HOLD   = 300;
  localparam int POOL_SIZE   = 24;
  localparam int PRINT_CAP   = 100;

  // Request code 3 is reserved and must leave the table untouched.
  localparam logic [ReqW-1:0]     REQ_RESERVED     = 2'd3;
  localparam logic [CfgAddrW-1:0] ADDR_BUCKET_LOG2 = 3'd0;

  typedef struct packed {
    status_e     status;
    logic [31:0] value;
    logic [8:0]  entries;
  } answer_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // Fields from bit 0: req_type, key, new_value, zero fill.
  logic [IN_W-1:0]      s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // Fields from bit 0: status, found_value, entry_count, zero fill.
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [CfgAddrW-1:0]  paddr;
  logic [CfgDataW-1:0]  pwdata;
  logic [CfgDataW-1:0]  prdata;
  logic                 pready;

  // Predicted table contents and the results still owed by the block.
  logic        tbl_valid [TABLE_SLOTS];
  logic [31:0] tbl_key   [TABLE_SLOTS];
  logic [31:0] tbl_value [TABLE_SLOTS];
  logic [8:0]  tbl_entries;
  logic [2:0]  tbl_log2;
  answer_t     pending_answers [$];

  int quiet_cycles = 0;
  int mismatches   = 0;
  bit gaps_on;
  bit stall_on;
  bit hold_request;

  hash_key_value_table uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Empties the predicted table, as reset and any bucket register write do.
  function automatic void empty_table();
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
    end
    tbl_entries = '0;
  endfunction

  // Applies one request to the predicted table and returns its result.
  function automatic answer_t apply_request(logic [1:0] req, logic [31:0] key,
                                            logic [31:0] val);
    answer_t     ans;
    int unsigned lg;
    int unsigned base;
    int unsigned hit;
    int unsigned vacant;
    bit          have_hit;
    bit          have_vacant;
    // An oversized register value selects the largest table.
    lg = (tbl_log2 > LOG2_CAP) ? LOG2_CAP : tbl_log2;
    base = (key & ((32'd1 << lg) - 32'd1)) * SLOTS;
    have_hit = 1'b0;
    have_vacant = 1'b0;
    hit = 0;
    vacant = 0;
    // The first matching slot wins; an insert takes the lowest free slot.
    for (int s = 0; s < SLOTS; s++) begin
      if (tbl_valid[base + s]) begin
        if (!have_hit && tbl_key[base + s] == key) begin
          have_hit = 1'b1;
          hit = base + s;
        end
      end else if (!have_vacant) begin
        have_vacant = 1'b1;
        vacant = base + s;
      end
    end
    ans.status = STAT_MISSING;
    ans.value = '0;
    case (req)
      REQ_INSERT: begin
        if (have_hit) begin
          tbl_value[hit] = val;
          ans.status = STAT_UPDATED;
        end else if (have_vacant) begin
          tbl_valid[vacant] = 1'b1;
          tbl_key[vacant] = key;
          tbl_value[vacant] = val;
          tbl_entries = tbl_entries + 9'd1;
          ans.status = STAT_INSERTED;
        end else begin
          ans.status = STAT_FULL;
        end
      end
      REQ_LOOKUP: begin
        if (have_hit) begin
          ans.status = STAT_FOUND;
          ans.value = tbl_value[hit];
        end
      end
      REQ_REMOVE: begin
        if (have_hit) begin
          tbl_valid[hit] = 1'b0;
          tbl_entries = tbl_entries - 9'd1;
          ans.status = STAT_FOUND;
        end
      end
      default: begin
      end
    endcase
    ans.entries = tbl_entries;
    return ans;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
  endtask

  // Checks result transfers, predicts request transfers and tracks
  // configuration writes, all sampled at the rising edge.
  always @(posedge clk_i) begin
    answer_t want;
    bit      busy;
    if (rst_ni) begin
      busy = 1'b0;
      if (m_axis_tvalid && m_axis_tready) begin
        busy = 1'b1;
        if (pending_answers.size() == 0) begin
          report_mismatch("unexpected result", 64'(m_axis_tdata), 64'd0);
        end else begin
          want = pending_answers.pop_front();
          if (m_axis_tdata[2:0] !== want.status)
            report_mismatch("status", 64'(m_axis_tdata[2:0]), 64'(want.status));
          if (m_axis_tdata[34:3] !== want.value)
            report_mismatch("found_value", 64'(m_axis_tdata[34:3]), 64'(want.value));
          if (m_axis_tdata[43:35] !== want.entries)
            report_mismatch("entry_count", 64'(m_axis_tdata[43:35]), 64'(want.entries));
          if (m_axis_tdata[47:44] !== 4'd0)
            report_mismatch("zero fill", 64'(m_axis_tdata[47:44]), 64'd0);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        busy = 1'b1;
        pending_answers = {pending_answers,
                           apply_request(s_axis_tdata[1:0], s_axis_tdata[33:2],
                                         s_axis_tdata[65:34])};
      end
      if (psel && penable && pwrite && pready) begin
        busy = 1'b1;
        if (paddr == ADDR_BUCKET_LOG2) begin
          tbl_log2 = pwdata[2:0];
          empty_table();
        end
      end
      quiet_cycles <= busy ? 0 : quiet_cycles + 1;
    end
  end

  // Ends the run when nothing has moved for too long.
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // Result side: random stalls, plus one long hold when a test asks for it.
  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (stall_on && $urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  // Sends one request; starts and ends at a falling edge. The valid stays
  // high into the next request when no gap follows.
  task automatic send_request(logic [1:0] req, logic [31:0] key, logic [31:0] val);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, val, key, req};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Stops sending and waits until every result has arrived and the block
  // has had time to finish any trailing work.
  task automatic wait_until_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Writes the bucket register while idle, with random upper data bits,
  // then reads it back.
  task automatic write_bucket_log2(logic [2:0] lg);
    logic [CfgDataW-1:0] word;
    wait_until_idle();
    word = $urandom;
    word[2:0] = lg;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BUCKET_LOG2;
    pwdata  <= word;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    // Read setup follows the write access directly.
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== CfgDataW'(lg)) report_mismatch("register readback", 64'(prdata), 64'(lg));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Every operation and corner case, at the register's reset setting.
  task automatic test_directed_ops();
    // Lookup and remove on an empty table miss.
    send_request(REQ_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(REQ_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
    // Extreme keys and values go in and come back.
    send_request(REQ_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Insert of a present key updates it.
    send_request(REQ_INSERT, 32'h0000_0000, 32'h1234_5678);
    send_request(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    // The reserved code changes nothing.
    send_request(REQ_RESERVED, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    // Fill bucket zero, then overflow it.
    send_request(REQ_INSERT, 32'h0000_0010, 32'hA5A5_0010);
    send_request(REQ_INSERT, 32'h0000_0020, 32'hA5A5_0020);
    send_request(REQ_INSERT, 32'h0000_0030, 32'hA5A5_0030);
    send_request(REQ_INSERT, 32'h0000_0040, 32'hA5A5_0040);
    send_request(REQ_LOOKUP, 32'h0000_0030, 32'h0000_0000);
    // Removing frees a slot that the next new key takes.
    send_request(REQ_REMOVE, 32'h0000_0010, 32'h0000_0000);
    send_request(REQ_LOOKUP, 32'h0000_0010, 32'h0000_0000);
    send_request(REQ_INSERT, 32'h0000_0040, 32'h5A5A_0040);
    send_request(REQ_INSERT, 32'h0000_0050, 32'h5A5A_0050);
    send_request(REQ_REMOVE, 32'h0000_0010, 32'h0000_0000);
    send_request(REQ_LOOKUP, 32'h0000_0040, 32'h0000_0000);
    // High key bits do not take part in the bucket choice.
    send_request(REQ_INSERT, 32'hFFFF_FFF0, 32'h0F0F_0F0F);
    send_request(REQ_LOOKUP, 32'hFFFF_FFF0, 32'h0000_0000);
  endtask

  // Fills every slot of the largest table, then overflows and probes it.
  task automatic test_fill_whole_table();
    logic [31:0] key;
    logic [31:0] keep [4];
    write_bucket_log2(3'(LOG2_CAP));
    for (int s = 0; s < SLOTS; s++) begin
      for (int b = 0; b < 2 ** LOG2_CAP; b++) begin
        key = $urandom;
        key[7:0] = {2'(s), 6'(b)};
        if (b == 9) keep[s] = key;
        send_request(REQ_INSERT, key, $urandom);
      end
    end
    key = $urandom;
    key[5:0] = 6'd9;
    send_request(REQ_INSERT, key, $urandom);
    for (int s = 0; s < SLOTS; s++) begin
      send_request(REQ_LOOKUP, keep[s], $urandom);
    end
    send_request(REQ_REMOVE, keep[2], $urandom);
    send_request(REQ_INSERT, key, $urandom);
    send_request(REQ_INSERT, keep[0], $urandom);
  endtask

  // The result side holds off for a long stretch while requests keep
  // coming, so the block fills up and stops accepting.
  task automatic test_output_backpressure();
    write_bucket_log2(3'd2);
    gaps_on = 1'b0;
    hold_request = 1'b1;
    for (int i = 0; i < 20; i++) begin
      send_request(2'($urandom_range(0, 2)), 32'($urandom_range(0, 15)), $urandom);
    end
    gaps_on = 1'b1;
  endtask

  // Random traffic over a pool of keys that crowds a few buckets, at
  // several register settings including both extremes.
  task automatic test_random_sweep();
    logic [2:0]  settings [8];
    logic [31:0] pool [POOL_SIZE];
    logic [31:0] key;
    logic [1:0]  req;
    int          roll;
    settings = '{3'd0, 3'd7, 3'd3, 3'd1, 3'd5, 3'd6, 3'd2, 3'd4};
    for (int p = 0; p < 8; p++) begin
      write_bucket_log2(settings[p]);
      gaps_on  = (p % 3) != 2;
      stall_on = (p % 4) != 1;
      for (int i = 0; i < POOL_SIZE; i++) begin
        pool[i] = $urandom;
        if (i % 2 == 0) pool[i][5:0] = 6'($urandom_range(0, 3));
      end
      for (int i = 0; i < 80; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 45)      req = REQ_INSERT;
        else if (roll < 75) req = REQ_LOOKUP;
        else if (roll < 95) req = REQ_REMOVE;
        else                req = REQ_RESERVED;
        if ($urandom_range(0, 99) < 85) key = pool[$urandom_range(0, POOL_SIZE - 1)];
        else key = $urandom;
        send_request(req, key, $urandom);
      end
    end
    gaps_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    gaps_on       = 1'b1;
    stall_on      = 1'b1;
    hold_request  = 1'b0;
    tbl_log2      = BucketLog2Reset;
    empty_table();
    rst_ni = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed_ops();
    test_fill_whole_table();
    test_output_backpressure();
    test_random_sweep();
    wait_until_idle();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
